// ----- src/cdus_pkg.sv -----
// ----------------------------------------------------------------------------
// cdus_pkg : shared types and constants for the civil date to unix seconds block
// widths, calendar constants, pipeline stage payloads and the month offset table
// ----------------------------------------------------------------------------
`default_nettype none

package cdus_pkg;

  // field widths of the beats
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 39;

  // calendar constants
  localparam int ERA_DAYS      = 146097;
  localparam int EPOCH_SHIFT   = 719468;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int YEAR_ERA      = 400;
  localparam int DAYS_YEAR     = 365;

  // era is carried biased by one so the shifted year never goes negative
  localparam int ERA_OFFSET = ERA_DAYS + EPOCH_SHIFT;

  // floor(x / 25) for x below 4681 as (x * 1311) >> 15
  localparam int DIV25_MUL   = 1311;
  localparam int DIV25_SHIFT = 15;
  localparam int DIV_PRE     = 4;   // 400 = 16 * 25

  // internal widths
  localparam int U_W    = 15;  // shifted year plus 400
  localparam int Q_W    = 6;   // era plus one
  localparam int YOE_W  = 9;   // year of era
  localparam int DOY_W  = 10;  // march based day of year, signed
  localparam int MB_W   = 9;   // month offset table entry
  localparam int TOD_W  = 17;  // seconds of the day
  localparam int DOE_W  = 19;  // day of era, signed
  localparam int DAYS_W = 24;  // days since epoch, signed
  localparam int RQ_W   = U_W - DIV_PRE + 10;  // reciprocal product

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } cdus_date_t;

  typedef struct packed {
    logic [U_W-1:0]   u;
    logic [DOY_W-1:0] doy;
    logic [TOD_W-1:0] tod;
  } cdus_s1_t;

  typedef struct packed {
    logic [U_W-1:0]   u;
    logic [Q_W-1:0]   q;
    logic [DOY_W-1:0] doy;
    logic [TOD_W-1:0] tod;
  } cdus_s2_t;

  typedef struct packed {
    logic [YOE_W-1:0] yoe;
    logic [Q_W-1:0]   q;
    logic [DOY_W-1:0] doy;
    logic [TOD_W-1:0] tod;
  } cdus_yoe_t;

  typedef struct packed {
    logic [DOE_W-1:0]  doe;
    logic [DAYS_W-1:0] era_base;
    logic [TOD_W-1:0]  tod;
  } cdus_s4_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } cdus_day_t;

  // (153 * march_month + 2) / 5, indexed by calendar month
  function automatic logic [MB_W-1:0] month_base(input logic [MONTH_W-1:0] mon);
    logic [MB_W-1:0] res;
    begin
      case (mon)
        4'd0:    res = 9'd275;
        4'd1:    res = 9'd306;
        4'd2:    res = 9'd337;
        4'd3:    res = 9'd0;
        4'd4:    res = 9'd31;
        4'd5:    res = 9'd61;
        4'd6:    res = 9'd92;
        4'd7:    res = 9'd122;
        4'd8:    res = 9'd153;
        4'd9:    res = 9'd184;
        4'd10:   res = 9'd214;
        4'd11:   res = 9'd245;
        4'd12:   res = 9'd275;
        4'd13:   res = 9'd306;
        4'd14:   res = 9'd337;
        default: res = 9'd367;
      endcase
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/cdus_ifs.sv -----
// ----------------------------------------------------------------------------
// cdus_ifs : beat channels of the civil date to unix seconds block
// valid/ready channels for the date beat and the epoch seconds beat
// ----------------------------------------------------------------------------
`default_nettype none

interface cdus_in_if import cdus_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cdus_out_if import cdus_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink   (input valid, epoch_seconds, output ready);
endinterface

`default_nettype wire

// ----- src/cdus_front.sv -----
// ----------------------------------------------------------------------------
// cdus_front : era and year-of-era stages
// three register stages: shifted year and day of year, era by reciprocal, year of era
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_front import cdus_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire cdus_date_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cdus_yoe_t       out_data
);

  logic      v1_r, v2_r, v3_r;
  logic      ld1, ld2, ld3;
  cdus_s1_t  s1_r, s1_nxt;
  cdus_s2_t  s2_r, s2_nxt;
  cdus_yoe_t s3_r, s3_nxt;
  logic [RQ_W-1:0] rq;
  logic [U_W-1:0]  yoe_full;

  // a stage loads when empty or when it drains this cycle
  assign ld3      = !v3_r || out_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  // shifted year biased by one era, day of year, seconds of day
  always_comb begin
    s1_nxt.u   = U_W'(in_data.year) + U_W'(YEAR_ERA)
               - U_W'((in_data.month <= MONTH_W'(2)) ? 1 : 0);
    s1_nxt.doy = DOY_W'(month_base(in_data.month)) + DOY_W'(in_data.day) - DOY_W'(1);
    s1_nxt.tod = TOD_W'(in_data.hour) * TOD_W'(SECS_PER_HOUR)
               + TOD_W'(in_data.minute) * TOD_W'(SECS_PER_MIN)
               + TOD_W'(in_data.second);
  end

  // u / 400 as (u / 16) / 25
  always_comb begin
    rq         = RQ_W'(s1_r.u[U_W-1:DIV_PRE]) * RQ_W'(DIV25_MUL);
    s2_nxt.u   = s1_r.u;
    s2_nxt.q   = rq[DIV25_SHIFT +: Q_W];
    s2_nxt.doy = s1_r.doy;
    s2_nxt.tod = s1_r.tod;
  end

  always_comb begin
    yoe_full   = s2_r.u - U_W'(s2_r.q) * U_W'(YEAR_ERA);
    s3_nxt.yoe = yoe_full[YOE_W-1:0];
    s3_nxt.q   = s2_r.q;
    s3_nxt.doy = s2_r.doy;
    s3_nxt.tod = s2_r.tod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) s1_r <= s1_nxt;
    if (ld2) s2_r <= s2_nxt;
    if (ld3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

`default_nettype wire

// ----- src/cdus_days.sv -----
// ----------------------------------------------------------------------------
// cdus_days : day count stages
// two register stages: day of era and era base, then days since epoch
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_days import cdus_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cdus_yoe_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output cdus_day_t      out_data
);

  logic      v4_r, v5_r;
  logic      ld4, ld5;
  cdus_s4_t  s4_r, s4_nxt;
  cdus_day_t s5_r, s5_nxt;
  logic [1:0] cent;

  assign ld5      = !v5_r || out_ready;
  assign ld4      = !v4_r || ld5;
  assign in_ready = ld4;

  // century count of the year of era
  always_comb begin
    if (in_data.yoe >= YOE_W'(300))      cent = 2'd3;
    else if (in_data.yoe >= YOE_W'(200)) cent = 2'd2;
    else if (in_data.yoe >= YOE_W'(100)) cent = 2'd1;
    else                                 cent = 2'd0;
  end

  always_comb begin
    s4_nxt.doe      = DOE_W'(in_data.yoe) * DOE_W'(DAYS_YEAR)
                    + DOE_W'(in_data.yoe >> 2) - DOE_W'(cent)
                    + {{(DOE_W-DOY_W){in_data.doy[DOY_W-1]}}, in_data.doy};
    s4_nxt.era_base = DAYS_W'(in_data.q) * DAYS_W'(ERA_DAYS) - DAYS_W'(ERA_OFFSET);
    s4_nxt.tod      = in_data.tod;
  end

  always_comb begin
    s5_nxt.days = s4_r.era_base + {{(DAYS_W-DOE_W){s4_r.doe[DOE_W-1]}}, s4_r.doe};
    s5_nxt.tod  = s4_r.tod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld4) v4_r <= in_valid;
      if (ld5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) s4_r <= s4_nxt;
    if (ld5) s5_r <= s5_nxt;
  end

  assign out_valid = v5_r;
  assign out_data  = s5_r;

endmodule

`default_nettype wire

// ----- src/cdus_scale.sv -----
// ----------------------------------------------------------------------------
// cdus_scale : seconds stage
// days times seconds per day plus seconds of day, registered as the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_scale import cdus_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cdus_day_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [EPOCH_W-1:0] out_data
);

  logic               v6_r;
  logic               ld6;
  logic [EPOCH_W-1:0] days_ext;
  logic [EPOCH_W-1:0] secs_r, secs_nxt;

  assign ld6      = !v6_r || out_ready;
  assign in_ready = ld6;

  // two's complement wraps to the output width
  always_comb begin
    days_ext = {{(EPOCH_W-DAYS_W){in_data.days[DAYS_W-1]}}, in_data.days};
    secs_nxt = days_ext * EPOCH_W'(SECS_PER_DAY) + EPOCH_W'(in_data.tod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (ld6) begin
      v6_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld6) secs_r <= secs_nxt;
  end

  assign out_valid = v6_r;
  assign out_data  = secs_r;

endmodule

`default_nettype wire

// ----- src/civil_date_to_unix_seconds.sv -----
// ----------------------------------------------------------------------------
// civil_date_to_unix_seconds : gregorian utc date and time to unix seconds
// days-from-civil conversion in a six stage pipeline with per stage stalls
// ----------------------------------------------------------------------------
//
//  channel   direction  beat payload                               accepted when
//  in_if     sink       year month day hour minute second          valid && ready
//  out_if    source     epoch_seconds (39 bit two's complement)    valid && ready
//
//  one beat per clock sustained while out_if.ready stays high, through six register stages
//  reset (rst_n low, synchronous) empties every stage; data registers keep their contents
//  each stage loads when empty or when the stage after it moves, so bubbles close up
//  a stalled output holds its beat and fills the stages behind it before in_if.ready drops
//  ready is combinational through the six stage chain back from out_if.ready
//
`default_nettype none

module civil_date_to_unix_seconds import cdus_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cdus_in_if.sink   in_if,
  cdus_out_if.source out_if
);

  cdus_date_t  date;
  cdus_yoe_t   yoe_bus;
  cdus_day_t   day_bus;
  logic        yoe_valid, yoe_ready;
  logic        day_valid, day_ready;
  logic [EPOCH_W-1:0] secs;

  // gather the beat fields for the front stages
  assign date.year   = in_if.year;
  assign date.month  = in_if.month;
  assign date.day    = in_if.day;
  assign date.hour   = in_if.hour;
  assign date.minute = in_if.minute;
  assign date.second = in_if.second;

  // stages one to three: march based year, era (biased by one) and year of era
  cdus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (date),
    .out_valid (yoe_valid),
    .out_ready (yoe_ready),
    .out_data  (yoe_bus)
  );

  // stages four and five: day of era, era base, days since epoch
  cdus_days u_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yoe_valid),
    .in_ready  (yoe_ready),
    .in_data   (yoe_bus),
    .out_valid (day_valid),
    .out_ready (day_ready),
    .out_data  (day_bus)
  );

  // stage six: scale to seconds, doubles as the output register
  cdus_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (day_valid),
    .in_ready  (day_ready),
    .in_data   (day_bus),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (secs)
  );

  assign out_if.epoch_seconds = secs;

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("output beat present after reset");

  // with the output register empty the whole chain can load
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled while output register empty");

  // back pressure only comes from a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready && yoe_valid && day_valid))
    else $error("input stalled with a free stage");

  // year of era stays inside one era
  a_yoe_range: assert property (@(posedge clk) disable iff (!rst_n)
    yoe_valid |-> (yoe_bus.yoe < YOE_W'(YEAR_ERA)))
    else $error("year of era out of range");

endmodule

`default_nettype wire

// ----- test/tb_civil_date_to_unix_seconds.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_civil_date_to_unix_seconds : self-checking bench for the date converter
// drives date beats from a queue, predicts unix seconds per beat and checks
// every output beat in order; random idling on both sides, one long sink stall
// ----------------------------------------------------------------------------

module tb_civil_date_to_unix_seconds;
  import cdus_pkg::*;

  localparam int RANDOM_DATES = 700;
  localparam int CALM_TAIL    = 120;     // last dates go out with no idling
  localparam int STALL_CYCLES = 80;      // long sink hold-off, fills the pipe
  localparam int STALL_AT     = 150;     // beats checked before the hold-off
  localparam int DRAIN_CYCLES = 20;      // idle time after the last beat is checked
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 30;

  // one conversion waiting at the output, kept with its date for reporting
  typedef struct {
    cdus_date_t                date;
    logic signed [EPOCH_W-1:0] secs;
  } epoch_due_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cdus_in_if  date_ch ();
  cdus_out_if epoch_ch ();

  civil_date_to_unix_seconds dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (date_ch),
    .out_if (epoch_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cdus_date_t date_queue[$];       // dates still to be offered
  epoch_due_t epoch_due[$];        // predicted seconds, oldest first
  int         dates_total     = 0;
  int         dates_sent      = 0;
  int         beats_checked   = 0;
  int         mismatches      = 0;
  int         input_stalls    = 0; // cycles the block held the sender back
  int         cycle_count     = 0;
  int         src_gap         = 0;
  int         sink_gap        = 0;
  int         hold_off_left   = 0;
  bit         hold_off_done   = 1'b0;

  // --------------------------------------------------------------------------
  // predictor: days-from-civil on 64 bit signed integers, then wrapped to the
  // 39 bit two's complement output
  // --------------------------------------------------------------------------
  function automatic logic signed [EPOCH_W-1:0] civil_to_epoch(input cdus_date_t d);
    longint yr, mon, dom, hr, mi, se;
    longint shifted_yr, era, yr_of_era, march_mon, day_of_yr, day_of_era;
    longint days, total;
    yr  = longint'(d.year);
    mon = longint'(d.month);
    dom = longint'(d.day);
    hr  = longint'(d.hour);
    mi  = longint'(d.minute);
    se  = longint'(d.second);
    // years start on march 1, so january and february count to the year before
    shifted_yr = (mon <= 2) ? yr - 1 : yr;
    // floor division for the one negative case (year zero, month two or below)
    era        = (shifted_yr >= 0) ? shifted_yr / 400 : (shifted_yr - 399) / 400;
    yr_of_era  = shifted_yr - era * 400;
    // month zero lands on index 9, months above twelve run on past february
    march_mon  = (mon > 2) ? mon - 3 : mon + 9;
    // day zero spills into the previous month, an overlong day into the next
    day_of_yr  = (153 * march_mon + 2) / 5 + dom - 1;
    day_of_era = yr_of_era * 365 + yr_of_era / 4 - yr_of_era / 100 + day_of_yr;
    days       = era * ERA_DAYS + day_of_era - EPOCH_SHIFT;
    total      = days * SECS_PER_DAY + hr * SECS_PER_HOUR + mi * SECS_PER_MIN + se;
    return total[EPOCH_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic queue_date(input int yr, input int mon, input int dom,
                            input int hr, input int mi, input int se);
    cdus_date_t d;
    d.year   = yr[YEAR_W-1:0];
    d.month  = mon[MONTH_W-1:0];
    d.day    = dom[DAY_W-1:0];
    d.hour   = hr[HOUR_W-1:0];
    d.minute = mi[MINUTE_W-1:0];
    d.second = se[SECOND_W-1:0];
    date_queue.push_back(d);
  endtask

  // random date: mostly plausible dates, some raw bit patterns, some corners
  function automatic cdus_date_t random_date();
    int         pick;
    int         edge_years[12] = '{0, 1, 399, 400, 1600, 1900, 1969, 1970, 2000,
                                   9999, 10680, 16383};
    int         edge_months[8] = '{0, 1, 2, 3, 12, 13, 14, 15};
    int         edge_days[6]   = '{0, 1, 28, 29, 30, 31};
    int         edge_hours[4]  = '{0, 23, 24, 31};
    int         edge_mins[3]   = '{0, 59, 63};
    int         edge_secs[4]   = '{0, 59, 60, 63};
    logic [63:0] raw;
    cdus_date_t d;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      d.year   = YEAR_W'($urandom_range(0, 9999));
      d.month  = MONTH_W'($urandom_range(1, 12));
      d.day    = DAY_W'($urandom_range(1, 31));
      d.hour   = HOUR_W'($urandom_range(0, 23));
      d.minute = MINUTE_W'($urandom_range(0, 59));
      d.second = SECOND_W'($urandom_range(0, 60));
    end else if (pick < 80) begin
      raw = {$urandom, $urandom};
      d   = raw[$bits(cdus_date_t)-1:0];
    end else begin
      d.year   = YEAR_W'(edge_years[$urandom_range(0, 11)]);
      d.month  = MONTH_W'(edge_months[$urandom_range(0, 7)]);
      d.day    = DAY_W'(edge_days[$urandom_range(0, 5)]);
      d.hour   = HOUR_W'(edge_hours[$urandom_range(0, 3)]);
      d.minute = MINUTE_W'(edge_mins[$urandom_range(0, 2)]);
      d.second = SECOND_W'(edge_secs[$urandom_range(0, 3)]);
    end
    return d;
  endfunction

  // idling comes and goes in windows, never during the long stall or the tail
  function automatic bit idling_allowed();
    return ((cycle_count / 400) % 3 != 2) && (hold_off_left == 0) &&
           (date_queue.size() > CALM_TAIL);
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers dates from the queue, holds a beat until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    epoch_due_t due;
    cdus_date_t d;
    if (!rst_n) begin
      date_ch.valid  <= 1'b0;
      date_ch.year   <= '0;
      date_ch.month  <= '0;
      date_ch.day    <= '0;
      date_ch.hour   <= '0;
      date_ch.minute <= '0;
      date_ch.second <= '0;
    end else begin
      if (date_ch.valid && date_ch.ready) begin
        due.date = {date_ch.year, date_ch.month, date_ch.day,
                    date_ch.hour, date_ch.minute, date_ch.second};
        due.secs = civil_to_epoch(due.date);
        epoch_due.push_back(due);
        dates_sent++;
      end
      if (date_ch.valid && !date_ch.ready) begin
        // beat not taken yet, keep it on the bus
        input_stalls++;
      end else begin
        if (src_gap == 0 && idling_allowed() && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 6);
        end
        if (src_gap != 0) begin
          src_gap--;
          date_ch.valid <= 1'b0;
        end else if (date_queue.size() != 0) begin
          d = date_queue.pop_front();
          date_ch.year   <= d.year;
          date_ch.month  <= d.month;
          date_ch.day    <= d.day;
          date_ch.hour   <= d.hour;
          date_ch.minute <= d.minute;
          date_ch.second <= d.second;
          date_ch.valid  <= 1'b1;
        end else begin
          date_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each output beat against the oldest prediction and
  // drives ready, with random bursts and one long hold-off to fill the pipe
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    epoch_due_t due;
    if (!rst_n) begin
      epoch_ch.ready <= 1'b0;
    end else begin
      if (epoch_ch.valid && epoch_ch.ready) begin
        if (epoch_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, epoch_seconds %0d",
                                    epoch_ch.epoch_seconds));
        end else begin
          due = epoch_due.pop_front();
          if (epoch_ch.epoch_seconds !== due.secs) begin
            report_mismatch($sformatf(
              "%0d-%0d-%0d %0d:%0d:%0d epoch_seconds got %0d want %0d",
              due.date.year, due.date.month, due.date.day, due.date.hour,
              due.date.minute, due.date.second, epoch_ch.epoch_seconds, due.secs));
          end
        end
        beats_checked++;
      end
      // the long stall is counted here, the sender keeps offering meanwhile
      if (!hold_off_done && beats_checked >= STALL_AT) begin
        hold_off_left = STALL_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        epoch_ch.ready <= 1'b0;
      end else begin
        if (sink_gap == 0 && idling_allowed() && $urandom_range(0, 9) == 0) begin
          sink_gap = $urandom_range(1, 6);
        end
        if (sink_gap != 0) begin
          sink_gap--;
          epoch_ch.ready <= 1'b0;
        end else begin
          epoch_ch.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               epoch_due.size());
      $display("tb_civil_date_to_unix_seconds failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // directed: epoch, year limits, era edges, leap days, odd months and days
    queue_date(1970,  1,  1,  0,  0,  0);   // the epoch itself
    queue_date(1969, 12, 31, 23, 59, 59);   // one second before
    queue_date(   0,  1,  1,  0,  0,  0);   // year zero january, era below zero
    queue_date(   0,  2, 29, 12, 30, 30);   // year zero february
    queue_date(   0,  3,  1,  0,  0,  0);   // first march based year
    queue_date(9999, 12, 31, 23, 59, 60);   // top of the nominal range, leap second
    queue_date(2000,  2, 29,  0,  0,  0);
    queue_date(1900,  3,  1,  0,  0,  0);
    queue_date(2024,  6, 30, 23, 59, 60);
    queue_date(2023,  0, 15,  8,  0,  0);   // month zero
    queue_date(2023, 13,  1,  0,  0,  0);   // months past twelve
    queue_date(2023, 14, 31,  0,  0,  0);
    queue_date(2023, 15, 31, 31, 63, 63);
    queue_date(2021,  2, 31,  0,  0,  0);   // day past month end
    queue_date(2021,  3,  0,  0,  0,  0);   // day zero
    queue_date(   0,  0,  0,  0,  0,  0);   // every field zero
    queue_date(16383, 15, 31, 31, 63, 63);  // every field all ones, wraps
    queue_date(10680, 12, 31, 23, 59, 59);  // close to the 39 bit limit
    queue_date(12000,  1,  1,  0,  0,  0);
    queue_date( 400,  1,  1,  0,  0,  0);
    queue_date( 399, 12, 31, 23, 59, 59);
    queue_date(1600,  2, 29,  0,  0,  0);
    queue_date(2038,  1, 19,  3, 14,  8);

    for (int i = 0; i < RANDOM_DATES; i++) begin
      date_queue.push_back(random_date());
    end
    dates_total = date_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (dates_sent != dates_total) @(posedge clk);
    while (epoch_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d dates (directed corners and random), %0d beats checked",
             dates_sent, beats_checked);
    $display("sender held back for %0d cycles, %0d mismatches", input_stalls, mismatches);
    if (mismatches == 0 && epoch_due.size() == 0) begin
      $display("tb_civil_date_to_unix_seconds passed");
    end else begin
      $display("tb_civil_date_to_unix_seconds failed");
    end
    $finish;
  end

endmodule
